### sv/lpd_pkg.sv
// Shared types and constants for the length-prefix deframer.
`default_nettype none

package lpd_pkg;

    // Link id field width and the number of ids it can name
    localparam int LinkIdW   = 4;
    localparam int LinkCount = 16;

    // Length header size in bytes, least significant byte first
    localparam int HeaderBytes = 4;
    localparam int HcntW       = 2;
    localparam int HpartW      = 24;

    // Input mode codes
    localparam logic [1:0] ModeData  = 2'd0;
    localparam logic [1:0] ModeOpen  = 2'd1;
    localparam logic [1:0] ModeClose = 2'd2;
    localparam logic [1:0] ModeRsvd  = 2'd3;

    // Result status codes
    localparam logic [1:0] StatPayload  = 2'd0;
    localparam logic [1:0] StatEmpty    = 2'd1;
    localparam logic [1:0] StatOversize = 2'd2;
    localparam logic [1:0] StatAbort    = 2'd3;

    // Register index (byte address bit 2)
    localparam logic RegMaxLen = 1'b0;

    // Input word
    typedef struct packed {
        logic [1:0]         mode;
        logic [LinkIdW-1:0] link_id;
        logic [7:0]         data_byte;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [LinkIdW-1:0] out_link;
        logic [7:0]         payload_byte;
        logic [1:0]         status;
        logic               first_of_packet;
        logic               last_of_packet;
    } t_out_word;

    // Classified command between front and back
    typedef struct packed {
        logic [1:0]         op;
        logic [LinkIdW-1:0] link;
        logic [7:0]         data_byte;
    } t_cmd;

    // Queue occupancy flags seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Framing state of one link
    typedef struct packed {
        logic              open;
        logic [HcntW-1:0]  hcnt;
        logic [HpartW-1:0] hpart;
        logic [31:0]       remain;
        logic              started;
        logic              discard;
    } t_link_state;

endpackage : lpd_pkg

`default_nettype wire

### sv/lpd_front.sv
// Front end: takes input words and drops the ones that never act on a link.
`default_nettype none

module lpd_front #(
    parameter int TRACKED_LINKS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  lpd_pkg::t_in_word     i_in_data,
    output logic                  o_in_stall,
    input  lpd_pkg::t_q_status    i_q_status,
    output logic                  o_push,
    output lpd_pkg::t_cmd         o_cmd
);

    logic accept;
    logic keep;

    // Stall only on a full queue
    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;

    // Mode 3 and links past the tracked range have no effect
    assign keep = (i_in_data.mode != lpd_pkg::ModeRsvd) &&
                  ({28'd0, i_in_data.link_id} < 32'(TRACKED_LINKS));

    assign o_push         = accept && keep;
    assign o_cmd.op        = i_in_data.mode;
    assign o_cmd.link      = i_in_data.link_id;
    assign o_cmd.data_byte = i_in_data.data_byte;

    // Nothing may enter a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_status.full |-> !o_push)
        else $error("push while queue full");

endmodule : lpd_front

`default_nettype wire

### sv/lpd_queue.sv
// Short command queue between the front and back ends.
`default_nettype none

module lpd_queue #(
    parameter int DEPTH = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  lpd_pkg::t_cmd         i_push_cmd,
    input  wire                   i_pop,
    output lpd_pkg::t_cmd         o_head,
    output lpd_pkg::t_q_status    o_status
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    lpd_pkg::t_cmd r_mem [DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_status.full  = (r_cnt == CntW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Fill count stays in range
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(DEPTH))
        else $error("queue count overflow");

endmodule : lpd_queue

`default_nettype wire

### sv/lpd_back.sv
// Back end: per-link framing state update and the result register.
`default_nettype none

module lpd_back #(
    parameter int TRACKED_LINKS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire [31:0]            i_max_len,
    input  lpd_pkg::t_q_status    i_q_status,
    input  lpd_pkg::t_cmd         i_cmd,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output lpd_pkg::t_out_word    o_out_data,
    input  wire                   i_out_stall
);

    localparam int IdxW = (TRACKED_LINKS > 1) ? $clog2(TRACKED_LINKS) : 1;

    lpd_pkg::t_link_state r_state [TRACKED_LINKS];
    lpd_pkg::t_link_state cur;
    lpd_pkg::t_link_state n_state;
    lpd_pkg::t_out_word   r_out;
    lpd_pkg::t_out_word   n_out;
    logic                 r_out_valid;
    logic                 has_result;
    logic [IdxW-1:0]      idx;
    logic [31:0]          len;
    logic                 hdr_done;
    logic                 mid;

    assign idx = i_cmd.link[IdxW-1:0];
    assign cur = r_state[idx];

    // Take the next word when the result register is free or draining
    assign o_pop = !i_q_status.empty && (!r_out_valid || !i_out_stall);

    // Header byte merged into the gathered length
    assign len = {8'd0, cur.hpart} | ({24'd0, i_cmd.data_byte} << {cur.hcnt, 3'b000});
    assign hdr_done = ({1'b0, cur.hcnt} + 3'd1) >= 3'(lpd_pkg::HeaderBytes);
    assign mid = !cur.discard && ((cur.hcnt != '0) || (cur.remain != '0));

    // Next state and result of the head word
    always_comb begin
        n_state    = cur;
        has_result = 1'b0;
        n_out                 = '0;
        n_out.out_link        = i_cmd.link;
        n_out.last_of_packet  = 1'b1;
        unique case (i_cmd.op)
            lpd_pkg::ModeOpen: begin
                if (!cur.open) begin
                    n_state      = '0;
                    n_state.open = 1'b1;
                end
            end
            lpd_pkg::ModeClose: begin
                if (cur.open) begin
                    n_state = '0;
                    if (mid) begin
                        has_result   = 1'b1;
                        n_out.status = lpd_pkg::StatAbort;
                    end
                end
            end
            lpd_pkg::ModeData: begin
                if (cur.open) begin
                    if (cur.remain != '0) begin
                        n_state.remain = cur.remain - 32'd1;
                        if (cur.discard) begin
                            if (cur.remain == 32'd1) begin
                                n_state.discard = 1'b0;
                            end
                        end else begin
                            has_result            = 1'b1;
                            n_out.status          = lpd_pkg::StatPayload;
                            n_out.payload_byte    = i_cmd.data_byte;
                            n_out.first_of_packet = !cur.started;
                            n_out.last_of_packet  = (cur.remain == 32'd1);
                            n_state.started       = (cur.remain != 32'd1);
                        end
                    end else if (!hdr_done) begin
                        // still gathering the length header
                        n_state.hpart = len[lpd_pkg::HpartW-1:0];
                        n_state.hcnt  = cur.hcnt + 1'b1;
                    end else begin
                        n_state.hcnt    = '0;
                        n_state.hpart   = '0;
                        n_state.started = 1'b0;
                        n_state.remain  = len;
                        if (len == '0) begin
                            has_result   = 1'b1;
                            n_out.status = lpd_pkg::StatEmpty;
                        end else if (len > i_max_len) begin
                            has_result      = 1'b1;
                            n_out.status    = lpd_pkg::StatOversize;
                            n_state.discard = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = cur;
            end
        endcase
    end

    // Link state table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TRACKED_LINKS; i++) begin
                r_state[i] <= '0;
            end
        end else if (o_pop) begin
            r_state[idx] <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= has_result;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Status results carry no byte and always close the packet
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != lpd_pkg::StatPayload)) |->
        (o_out_data.payload_byte == 8'd0 && !o_out_data.first_of_packet &&
         o_out_data.last_of_packet))
        else $error("malformed status result");

    // A processed close leaves the link closed
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.op == lpd_pkg::ModeClose) |=> !r_state[$past(idx)].open)
        else $error("link still open after close");

    // A held result is not overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !o_pop)
        else $error("result overwritten while stalled");

endmodule : lpd_back

`default_nettype wire

### sv/length_prefix_deframer_core.sv
// Top level of the length-prefix deframer: config register, front, queue, back.
//
//  Channel  Dir  Handshake                  Word
//  in       in   i_in_valid / o_in_stall    lpd_pkg::t_in_word (mode, link, byte)
//  out      out  o_out_valid / i_out_stall  lpd_pkg::t_out_word (link, byte, marks)
//  cfg      in   psel/penable/pwrite/pready max_packet_len at byte address 0
//
//  One word per cycle sustained while the output does not stall; an accepted
//  word is written into the queue first, and its state update and result load
//  follow once it is the head of the queue and is popped.
//  The rate is set by the read-modify-write of the link state table on each pop.
//  Synchronous active-low reset clears all links to closed and the limit to all ones.
//  Output stall fills the four-entry queue, after which o_in_stall rises.
`default_nettype none

module length_prefix_deframer_core #(
    parameter int NUM_LINKS = 16,
    parameter int Q_DEPTH   = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input words
    input  wire                   i_in_valid,
    input  lpd_pkg::t_in_word     i_in_data,
    output logic                  o_in_stall,
    // result words
    output logic                  o_out_valid,
    output lpd_pkg::t_out_word    o_out_data,
    input  wire                   i_out_stall,
    // register port
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire [2:0]             paddr,
    input  wire [31:0]            pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // Link ids only reach 16 entries, so that bounds the table
    localparam int TrackedLinks = (NUM_LINKS < lpd_pkg::LinkCount) ?
                                  NUM_LINKS : lpd_pkg::LinkCount;

    logic [31:0]        r_max_len;
    logic               push;
    logic               pop;
    lpd_pkg::t_cmd      push_cmd;
    lpd_pkg::t_cmd      head;
    lpd_pkg::t_q_status q_status;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == lpd_pkg::RegMaxLen) ? r_max_len : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 32'hFFFF_FFFF;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == lpd_pkg::RegMaxLen)) begin
            r_max_len <= pwdata;
        end
    end

    lpd_front #(
        .TRACKED_LINKS (TrackedLinks)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    lpd_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    lpd_back #(
        .TRACKED_LINKS (TrackedLinks)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_len   (r_max_len),
        .i_q_status  (q_status),
        .i_cmd       (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule : length_prefix_deframer_core

`default_nettype wire
